### src/chained_hash_table_defines.svh
// Assertion macros shared by the hash table checkers.
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hash table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hash table check failed");

`endif

### src/cht_pkg.sv
// Shared types, sizes and state codes for the chained hash table.
package cht_pkg;

	// Bucket count must stay a power of two: the bucket is the low key bits.
	localparam int unsigned BUCKETS   = 4096;
	localparam int unsigned ENTRIES   = 4096;
	localparam int unsigned BKT_W     = $clog2(BUCKETS);
	localparam int unsigned ENT_IDX_W = $clog2(ENTRIES);
	localparam int unsigned PTR_W     = $clog2(ENTRIES + 1);
	localparam int unsigned KEY_W     = 64;
	localparam int unsigned VAL_W     = 32;

	localparam logic [PTR_W-1:0] ENT_MAX  = PTR_W'(ENTRIES);
	localparam logic [PTR_W-1:0] STEP_MAX = PTR_W'(ENTRIES - 1);

	localparam logic CMD_ACCESS = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [KEY_W-1:0] lookup_key;
		logic             write_enable;
		logic [VAL_W-1:0] write_value;
	} in_item_t;

	typedef struct packed {
		logic [VAL_W-1:0] old_value;
		logic             hit;
		logic             inserted;
		logic             table_full;
		logic [PTR_W-1:0] entries_used;
	} out_item_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [PTR_W-1:0] next;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [BKT_W-1:0] waddr;
		logic [PTR_W-1:0] wdata;
		logic             re;
		logic [BKT_W-1:0] raddr;
	} head_req_t;

	typedef struct packed {
		logic                 we;
		logic [ENT_IDX_W-1:0] waddr;
		entry_t               wdata;
		logic                 re;
		logic [ENT_IDX_W-1:0] raddr;
	} entry_req_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_HEAD,
		ST_WALK,
		ST_MISS,
		ST_CLEAR,
		ST_DONE
	} state_t;

endpackage

### src/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cht_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/cht_walk.sv
// Sequencer and shared key comparator that walk, extend and clear the chains.
module cht_walk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  cht_pkg::in_item_t   in_data,
	output logic                in_ready,
	output logic                res_valid,
	input  logic                res_ready,
	output cht_pkg::out_item_t  res,
	output cht_pkg::head_req_t  head_req,
	input  logic [cht_pkg::PTR_W-1:0] head_rd,
	output cht_pkg::entry_req_t entry_req,
	input  cht_pkg::entry_t     entry_rd
);

	cht_pkg::state_t    state_q, state_d;
	cht_pkg::in_item_t  item_q;
	cht_pkg::out_item_t res_q;
	logic [cht_pkg::PTR_W-1:0] head_q;
	logic [cht_pkg::PTR_W-1:0] cur_q;
	logic [cht_pkg::PTR_W-1:0] steps_q;
	logic [cht_pkg::PTR_W-1:0] used_q;
	logic [cht_pkg::BKT_W-1:0] sweep_q;

	logic                      key_eq;
	logic                      next_ok;
	logic                      head_ok;
	logic                      pool_full;
	logic                      sweep_last;
	logic [cht_pkg::PTR_W-1:0] new_ptr;
	logic [cht_pkg::BKT_W-1:0] bucket;

	// Entry numbers run from 1; the RAM row is one less.
	function automatic logic [cht_pkg::ENT_IDX_W-1:0] row_of(
		input logic [cht_pkg::PTR_W-1:0] ptr
	);
		logic [cht_pkg::PTR_W-1:0] t;
		t = ptr - 1'b1;
		return t[cht_pkg::ENT_IDX_W-1:0];
	endfunction

	assign key_eq     = (entry_rd.key == item_q.lookup_key);
	assign next_ok    = (entry_rd.next != '0) && (entry_rd.next <= cht_pkg::ENT_MAX)
		&& (steps_q != cht_pkg::STEP_MAX);
	assign head_ok    = (head_rd != '0) && (head_rd <= cht_pkg::ENT_MAX);
	assign pool_full  = (used_q >= cht_pkg::ENT_MAX);
	assign sweep_last = (sweep_q == '1);
	assign new_ptr    = used_q + 1'b1;
	assign bucket     = item_q.lookup_key[cht_pkg::BKT_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cht_pkg::ST_INIT: begin
				if (sweep_last) begin
					state_d = cht_pkg::ST_IDLE;
				end
			end
			cht_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_data.cmd == cht_pkg::CMD_CLEAR) ? cht_pkg::ST_CLEAR
						: cht_pkg::ST_HEAD;
				end
			end
			cht_pkg::ST_HEAD: begin
				state_d = head_ok ? cht_pkg::ST_WALK : cht_pkg::ST_MISS;
			end
			cht_pkg::ST_WALK: begin
				priority if (key_eq) begin
					state_d = cht_pkg::ST_DONE;
				end else if (!next_ok) begin
					state_d = cht_pkg::ST_MISS;
				end else begin
					state_d = cht_pkg::ST_WALK;
				end
			end
			cht_pkg::ST_MISS: begin
				state_d = cht_pkg::ST_DONE;
			end
			cht_pkg::ST_CLEAR: begin
				if (sweep_last) begin
					state_d = cht_pkg::ST_DONE;
				end
			end
			cht_pkg::ST_DONE: begin
				if (res_ready) begin
					state_d = cht_pkg::ST_IDLE;
				end
			end
			default: state_d = cht_pkg::ST_INIT;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		res_valid       = 1'b0;
		head_req        = '0;
		entry_req       = '0;
		head_req.raddr  = in_data.lookup_key[cht_pkg::BKT_W-1:0];
		entry_req.raddr = row_of(head_rd);
		unique case (state_q)
			cht_pkg::ST_INIT, cht_pkg::ST_CLEAR: begin
				head_req.we    = 1'b1;
				head_req.waddr = sweep_q;
				head_req.wdata = '0;
			end
			cht_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				head_req.re = 1'b1;
			end
			cht_pkg::ST_HEAD: begin
				entry_req.re = head_ok;
			end
			cht_pkg::ST_WALK: begin
				entry_req.re          = !key_eq && next_ok;
				entry_req.raddr       = row_of(entry_rd.next);
				// Rewrite the found entry with the new value, same key and link.
				entry_req.we          = key_eq && item_q.write_enable;
				entry_req.waddr       = row_of(cur_q);
				entry_req.wdata.key   = entry_rd.key;
				entry_req.wdata.value = item_q.write_value;
				entry_req.wdata.next  = entry_rd.next;
			end
			cht_pkg::ST_MISS: begin
				entry_req.we          = !pool_full;
				entry_req.waddr       = row_of(new_ptr);
				entry_req.wdata.key   = item_q.lookup_key;
				entry_req.wdata.value = item_q.write_enable ? item_q.write_value : '0;
				entry_req.wdata.next  = head_q;
				head_req.we           = !pool_full;
				head_req.waddr        = bucket;
				head_req.wdata        = new_ptr;
			end
			cht_pkg::ST_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cht_pkg::ST_INIT;
			used_q  <= '0;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == cht_pkg::ST_INIT || state_q == cht_pkg::ST_CLEAR) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (state_q == cht_pkg::ST_CLEAR) begin
				used_q <= '0;
			end
			if (state_q == cht_pkg::ST_MISS && !pool_full) begin
				used_q <= new_ptr;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			cht_pkg::ST_IDLE: begin
				if (in_valid) begin
					item_q <= in_data;
				end
			end
			cht_pkg::ST_HEAD: begin
				head_q  <= head_ok ? head_rd : '0;
				cur_q   <= head_rd;
				steps_q <= '0;
			end
			cht_pkg::ST_WALK: begin
				if (key_eq) begin
					res_q.old_value    <= entry_rd.value;
					res_q.hit          <= 1'b1;
					res_q.inserted     <= 1'b0;
					res_q.table_full   <= 1'b0;
					res_q.entries_used <= used_q;
				end else begin
					cur_q   <= entry_rd.next;
					steps_q <= steps_q + 1'b1;
				end
			end
			cht_pkg::ST_MISS: begin
				res_q.old_value    <= '0;
				res_q.hit          <= 1'b0;
				res_q.inserted     <= !pool_full;
				res_q.table_full   <= pool_full;
				res_q.entries_used <= pool_full ? used_q : new_ptr;
			end
			cht_pkg::ST_CLEAR: begin
				res_q <= '0;
			end
			default: begin
			end
		endcase
	end

endmodule

### src/chained_hash_table.sv
// Top level of the chained hash table: chain walker, memories and result register.
// An access runs through these steps in order: accept, bucket head read, one entry
// compare per cycle on the single key comparator until the match or the end of the
// chain, insert on a miss while entries are free, hand-off to the result register.
// A clear item sweeps the bucket head memory one row a cycle. After reset the same
// sweep runs over every bucket before in_ready first rises.
// The result register frees the walker as soon as a result is moved into it, so the
// next item is taken while an earlier result still waits for out_ready.
module chained_hash_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cht_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output cht_pkg::out_item_t out_data
);

	cht_pkg::head_req_t  head_req;
	cht_pkg::entry_req_t entry_req;
	cht_pkg::entry_t     entry_rd;
	cht_pkg::out_item_t  res;
	cht_pkg::out_item_t  out_q;
	logic [cht_pkg::PTR_W-1:0] head_rd;
	logic                res_valid;
	logic                res_ready;
	logic                out_valid_q;

	cht_ram #(
		.WIDTH(cht_pkg::PTR_W),
		.DEPTH(cht_pkg::BUCKETS)
	) u_head_ram (
		.clk  (clk),
		.we   (head_req.we),
		.waddr(head_req.waddr),
		.wdata(head_req.wdata),
		.re   (head_req.re),
		.raddr(head_req.raddr),
		.rdata(head_rd)
	);

	cht_ram #(
		.WIDTH($bits(cht_pkg::entry_t)),
		.DEPTH(cht_pkg::ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (entry_req.we),
		.waddr(entry_req.waddr),
		.wdata(entry_req.wdata),
		.re   (entry_req.re),
		.raddr(entry_req.raddr),
		.rdata(entry_rd)
	);

	cht_walk u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_data  (in_data),
		.in_ready (in_ready),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.head_req (head_req),
		.head_rd  (head_rd),
		.entry_req(entry_req),
		.entry_rd (entry_rd)
	);

	// Take a new result when the register is empty or drains this cycle.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### src/cht_chk.sv
// Port-level checks on the hash table results, bound to the top level.
`include "chained_hash_table_defines.svh"

module cht_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input cht_pkg::out_item_t out_data
);

	logic [2:0] flags;

	assign flags = {out_data.hit, out_data.inserted, out_data.table_full};

	`CHT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`CHT_ASSERT_IMPLY(a_one_outcome, clk, arst_n, out_valid, $onehot0(flags))
	`CHT_ASSERT_IMPLY(a_old_only_on_hit, clk, arst_n, out_valid && out_data.old_value != '0, out_data.hit)
	`CHT_ASSERT_IMPLY(a_full_means_max, clk, arst_n, out_valid && out_data.table_full, out_data.entries_used == cht_pkg::ENT_MAX)
	`CHT_ASSERT_IMPLY(a_insert_counts, clk, arst_n, out_valid && (out_data.inserted || out_data.hit), out_data.entries_used != '0)

endmodule

bind chained_hash_table cht_chk u_cht_chk (.*);

### tb/sv/chained_hash_table_tb.sv
// Self-checking testbench for chained_hash_table: queued random and directed traffic, scoreboard.
module chained_hash_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned PHASE_ITEMS   = 490;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned TAIL_CYCLES   = 32;
	localparam int unsigned KEY_POOL_MAX  = 512;
	localparam int unsigned HOT_BUCKETS   = 4;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	cht_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	cht_pkg::out_item_t out_data;

	// Own copy of the table contents
	logic [cht_pkg::PTR_W-1:0] chain_head [cht_pkg::BUCKETS];
	logic [cht_pkg::KEY_W-1:0] slot_key   [1:cht_pkg::ENTRIES];
	logic [cht_pkg::VAL_W-1:0] slot_value [1:cht_pkg::ENTRIES];
	logic [cht_pkg::PTR_W-1:0] slot_next  [1:cht_pkg::ENTRIES];
	logic [cht_pkg::PTR_W-1:0] slots_used;

	cht_pkg::in_item_t         cmd_backlog [$];
	cht_pkg::out_item_t        results_due [$];
	cht_pkg::out_item_t        due_result;
	logic [cht_pkg::KEY_W-1:0] key_pool [$];
	logic [cht_pkg::BKT_W-1:0] hot_bucket [HOT_BUCKETS];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_len = 0;
	int unsigned hold_seq = 0;
	int unsigned hold_seen;
	int unsigned hold_left;
	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;

	chained_hash_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #2 clk = ~clk;

	// Apply one item to the table copy and return the result it produces.
	function automatic cht_pkg::out_item_t table_apply(input cht_pkg::in_item_t item);
		cht_pkg::out_item_t        res;
		int unsigned               b;
		int unsigned               steps;
		logic [cht_pkg::PTR_W-1:0] idx;
		logic                      found;
		res = '0;
		if (item.cmd == cht_pkg::CMD_CLEAR) begin
			foreach (chain_head[i])
				chain_head[i] = '0;
			slots_used = '0;
		end else begin
			b = int'(item.lookup_key % 64'(cht_pkg::BUCKETS));
			idx = chain_head[b];
			steps = 0;
			found = 1'b0;
			while (idx != '0 && idx <= cht_pkg::ENT_MAX && steps < cht_pkg::ENTRIES
					&& !found) begin
				if (slot_key[idx] == item.lookup_key) begin
					found = 1'b1;
				end else begin
					idx = slot_next[idx];
					steps++;
				end
			end
			if (!found)
				idx = '0;
			if (found) begin
				res.hit = 1'b1;
				res.old_value = slot_value[idx];
			end else if (slots_used >= cht_pkg::ENT_MAX) begin
				res.table_full = 1'b1;
			end else begin
				// link a fresh entry at the chain head
				slots_used = slots_used + 1'b1;
				idx = slots_used;
				slot_key[idx] = item.lookup_key;
				slot_value[idx] = '0;
				slot_next[idx] = chain_head[b];
				chain_head[b] = idx;
				res.inserted = 1'b1;
			end
			if (idx != '0 && item.write_enable)
				slot_value[idx] = item.write_value;
		end
		res.entries_used = slots_used;
		return res;
	endfunction

	task automatic queue_item(input logic cmd, input logic [cht_pkg::KEY_W-1:0] key,
			input logic we, input logic [cht_pkg::VAL_W-1:0] wv);
		cht_pkg::in_item_t item;
		item.cmd = cmd;
		item.lookup_key = key;
		item.write_enable = we;
		item.write_value = wv;
		cmd_backlog.push_back(item);
	endtask

	task automatic queue_random_item();
		logic [cht_pkg::KEY_W-1:0] key;
		logic [cht_pkg::VAL_W-1:0] wv;
		int unsigned               roll;
		key = {$urandom, $urandom};
		roll = $urandom_range(0, 99);
		if (roll < 40 && key_pool.size() != 0)
			key = key_pool[$urandom_range(0, key_pool.size() - 1)];
		else if (roll < 65)
			key[cht_pkg::BKT_W-1:0] = hot_bucket[$urandom_range(0, HOT_BUCKETS - 1)];
		if (key_pool.size() < KEY_POOL_MAX)
			key_pool.push_back(key);
		else
			key_pool[$urandom_range(0, KEY_POOL_MAX - 1)] = key;
		roll = $urandom_range(0, 9);
		wv = (roll == 0) ? '0 : (roll == 1) ? '1 : cht_pkg::VAL_W'($urandom);
		if ($urandom_range(0, 199) == 0)
			queue_item(cht_pkg::CMD_CLEAR, key, 1'($urandom), wv);
		else
			queue_item(cht_pkg::CMD_ACCESS, key, 1'($urandom), wv);
	endtask

	// Wait until every queued item is transferred and every result is back.
	task automatic wait_drain();
		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || in_valid || results_due.size() != 0);
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Driver: predict on each input transfer, then offer the next item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				results_due.push_back(table_apply(in_data));
			if (!in_valid || in_ready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= cmd_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each output transfer, then decide on back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("result transfer with no expected result pending");
					mismatches++;
				end else begin
					due_result = results_due.pop_front();
					compare_field("old_value", 64'(due_result.old_value),
						64'(out_data.old_value));
					compare_field("hit", 64'(due_result.hit), 64'(out_data.hit));
					compare_field("inserted", 64'(due_result.inserted), 64'(out_data.inserted));
					compare_field("table_full", 64'(due_result.table_full),
						64'(out_data.table_full));
					compare_field("entries_used", 64'(due_result.entries_used),
						64'(out_data.entries_used));
				end
			end
			if (hold_seq != hold_seen) begin
				hold_seen <= hold_seq;
				hold_left <= hold_len;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int unsigned send_pct [4];
		int unsigned recv_pct [4];
		send_pct = '{0, 75, 0, 19};
		recv_pct = '{0, 0, 75, 19};
		foreach (chain_head[i])
			chain_head[i] = '0;
		slots_used = '0;
		hot_bucket[0] = '0;
		hot_bucket[1] = '1;
		for (int i = 2; i < HOT_BUCKETS; i++)
			hot_bucket[i] = cht_pkg::BKT_W'($urandom);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: key extremes, writes on hit and miss, shared buckets, clears.
		queue_item(cht_pkg::CMD_ACCESS, 64'h0, 1'b1, '1);
		queue_item(cht_pkg::CMD_ACCESS, 64'h0, 1'b0, '0);
		queue_item(cht_pkg::CMD_ACCESS, '1, 1'b1, '0);
		queue_item(cht_pkg::CMD_ACCESS, '1, 1'b1, 32'h1234_5678);
		queue_item(cht_pkg::CMD_ACCESS, '1, 1'b0, '1);
		queue_item(cht_pkg::CMD_ACCESS, 64'h1000, 1'b0, 32'hdead_beef);
		queue_item(cht_pkg::CMD_ACCESS, 64'h2000, 1'b1, 32'ha5a5_a5a5);
		queue_item(cht_pkg::CMD_ACCESS, 64'h8000_0000_0000_0000, 1'b1, 32'h5a5a_5a5a);
		queue_item(cht_pkg::CMD_ACCESS, 64'h0, 1'b0, '0);
		queue_item(cht_pkg::CMD_ACCESS, 64'h1000, 1'b0, '0);
		queue_item(cht_pkg::CMD_ACCESS, 64'h0fff, 1'b1, 32'h1);
		queue_item(cht_pkg::CMD_ACCESS, '1, 1'b0, '0);
		queue_item(cht_pkg::CMD_CLEAR, '1, 1'b1, '1);
		queue_item(cht_pkg::CMD_ACCESS, '1, 1'b0, '0);
		queue_item(cht_pkg::CMD_ACCESS, 64'h0, 1'b1, '0);
		queue_item(cht_pkg::CMD_CLEAR, 64'h0, 1'b0, '0);
		wait_drain();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_pct[p];
			recv_stall_pct = recv_pct[p];
			repeat (PHASE_ITEMS) queue_random_item();
			if (p == 0) begin
				// stall the output long enough to back up the input
				hold_len = HOLD_CYCLES;
				hold_seq++;
			end
			wait_drain();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && results_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
